FILE: rtl/core/ccd_pkg.sv
// Shared types, constants and register indexes of the chunk deframer.
package ccd_pkg;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgMaxPayload = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgCrcEnable  = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgBigEndian  = 8'd2;

  localparam logic [15:0] MaxPayloadReset = 16'd65530;

  localparam logic [31:0] CrcPoly     = 32'h0000_BEEF;
  localparam logic [31:0] CrcInit     = 32'hC001_F00D;
  localparam logic [31:0] CrcPolyRefl = {<<{CrcPoly}};
  localparam logic [31:0] CrcInitRefl = {<<{CrcInit}};

  localparam logic [2:0] HdrLenHi  = 3'd4;
  localparam logic [2:0] HdrCrcEnd = 3'd4;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBadCrc  = 2'd1,
    StTooLong = 2'd2
  } ccd_status_e;

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhPayload = 2'd1,
    PhDrop    = 2'd2
  } ccd_phase_e;

  typedef struct packed {
    logic [15:0] max_payload;
    logic        crc_check_enable;
    logic        header_big_endian;
  } ccd_cfg_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        chunk_end;
    ccd_status_e chunk_status;
  } ccd_result_t;

endpackage

FILE: rtl/core/ccd_if.sv
// Request channels of the chunk deframer: input bytes and results.
interface ccd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface ccd_out_if
  import ccd_pkg::*;
();
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        has_byte;
  logic        chunk_end;
  ccd_status_e chunk_status;

  modport source (output valid, output out_byte, output has_byte, output chunk_end,
                  output chunk_status, input ready);
  modport sink   (input valid, input out_byte, input has_byte, input chunk_end,
                  input chunk_status, output ready);
endinterface

FILE: rtl/core/ccd_core.sv
// Chunk parser: header capture, length check, payload CRC and status.
module ccd_core
  import ccd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  ccd_cfg_t    cfg_i,
  output logic        res_valid_o,
  output ccd_result_t res_o
);

  ccd_phase_e  phase_q, phase_d;
  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic [31:0] rx_crc_q, rx_crc_d;
  logic [15:0] remain_q, remain_d;
  logic [31:0] run_crc_q, run_crc_d;

  logic [31:0] crc_next;
  logic [15:0] len_full;
  logic [15:0] remain_dec;

  function automatic logic [31:0] crc_byte(logic [31:0] c_in, logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPolyRefl) : (c >> 1);
    end
    return c;
  endfunction

  function automatic ccd_status_e crc_status(logic en, logic [31:0] run, logic [31:0] rx);
    return (en && (run != rx)) ? StBadCrc : StOk;
  endfunction

  assign crc_next   = crc_byte(run_crc_q, byte_i);
  assign remain_dec = remain_q - 16'd1;
  assign len_full   = cfg_i.header_big_endian ? {remain_q[15:8], byte_i}
                                              : {byte_i, remain_q[7:0]};

  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    rx_crc_d    = rx_crc_q;
    remain_d    = remain_q;
    run_crc_d   = run_crc_q;
    res_valid_o = 1'b0;
    res_o       = '{out_byte: 8'h00, has_byte: 1'b0, chunk_end: 1'b0, chunk_status: StOk};
    unique case (phase_q)
      PhHeader: begin
        if (hdr_cnt_q < HdrCrcEnd) begin
          if (cfg_i.header_big_endian) begin
            rx_crc_d = {rx_crc_q[23:0], byte_i};
          end else begin
            rx_crc_d = rx_crc_q | ({24'h0, byte_i} << {hdr_cnt_q[1:0], 3'b000});
          end
          hdr_cnt_d = hdr_cnt_q + 3'd1;
        end else if (hdr_cnt_q == HdrLenHi) begin
          remain_d  = cfg_i.header_big_endian ? {byte_i, 8'h00} : {8'h00, byte_i};
          hdr_cnt_d = hdr_cnt_q + 3'd1;
        end else begin
          hdr_cnt_d   = 3'd0;
          res_o.chunk_end = 1'b1;
          if (len_full > cfg_i.max_payload) begin
            // oversize chunk: report and drop everything until reset
            phase_d            = PhDrop;
            remain_d           = len_full;
            res_valid_o        = 1'b1;
            res_o.chunk_status = StTooLong;
          end else if (len_full == 16'd0) begin
            res_valid_o        = 1'b1;
            res_o.chunk_status = crc_status(cfg_i.crc_check_enable, run_crc_q, rx_crc_q);
            rx_crc_d           = '0;
            remain_d           = '0;
            run_crc_d          = CrcInitRefl;
          end else begin
            phase_d  = PhPayload;
            remain_d = len_full;
          end
        end
      end
      PhPayload: begin
        res_valid_o    = 1'b1;
        res_o.out_byte = byte_i;
        res_o.has_byte = 1'b1;
        run_crc_d      = crc_next;
        remain_d       = remain_dec;
        if (remain_dec == 16'd0) begin
          res_o.chunk_end    = 1'b1;
          res_o.chunk_status = crc_status(cfg_i.crc_check_enable, crc_next, rx_crc_q);
          phase_d            = PhHeader;
          hdr_cnt_d          = 3'd0;
          rx_crc_d           = '0;
          run_crc_d          = CrcInitRefl;
        end
      end
      default: begin
        // hold in drop
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHeader;
      hdr_cnt_q <= 3'd0;
      rx_crc_q  <= '0;
      remain_q  <= '0;
      run_crc_q <= CrcInitRefl;
    end else if (step_i) begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      rx_crc_q  <= rx_crc_d;
      remain_q  <= remain_d;
      run_crc_q <= run_crc_d;
    end
  end

endmodule

FILE: rtl/core/crc_chunk_deframer.sv
// Chunk deframer top level: input register, parser step, result register.
// Bytes are parsed on leaving the input register; results are registered.
// Throughput: one byte per cycle while results are taken; the two registers
// decouple the channels; an empty input stage accepts while a result waits.
// Reset: asynchronous, active low; parser returns to the header phase,
// registers take their reset values, both pipeline stages empty.
module crc_chunk_deframer
  import ccd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  ccd_in_if.sink              in_chan,
  ccd_out_if.source           out_chan
);

  ccd_cfg_t    cfg_q;
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        out_valid_q;
  ccd_result_t out_q;
  logic        out_free;
  logic        s1_adv;
  logic        res_valid;
  ccd_result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_payload       <= MaxPayloadReset;
      cfg_q.crc_check_enable  <= 1'b1;
      cfg_q.header_big_endian <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgMaxPayload: cfg_q.max_payload       <= cfg_data_i;
        CfgCrcEnable:  cfg_q.crc_check_enable  <= cfg_data_i[0];
        CfgBigEndian:  cfg_q.header_big_endian <= cfg_data_i[0];
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  assign out_free     = !out_valid_q || out_chan.ready;
  assign s1_adv       = s1_valid_q && out_free;
  assign in_chan.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_byte_q <= in_chan.in_byte;
    end
  end

  ccd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_adv),
    .byte_i      (s1_byte_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= res_valid;
    end else if (out_chan.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && res_valid) begin
      out_q <= res;
    end
  end

  assign out_chan.valid        = out_valid_q;
  assign out_chan.out_byte     = out_q.out_byte;
  assign out_chan.has_byte     = out_q.has_byte;
  assign out_chan.chunk_end    = out_q.chunk_end;
  assign out_chan.chunk_status = out_q.chunk_status;

  a_mid_chunk_carries_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.chunk_end |-> out_q.has_byte && out_q.chunk_status == StOk)
    else $error("mid-chunk result without byte or with status");

  a_empty_result_ends_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.has_byte |-> out_q.chunk_end && out_q.out_byte == 8'h00)
    else $error("byteless result not at chunk end");

  a_too_long_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.chunk_status == StTooLong |-> !out_q.has_byte)
    else $error("too_long status on a payload byte");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_byte_q))
    else $error("input stage lost a byte while the result stage was full");

endmodule

FILE: bench/crc_chunk_deframer_tb.sv
// Self-checking bench for the chunk deframer: header parsing, CRC verdicts, registers, lockout.
module crc_chunk_deframer_tb;
  import ccd_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 6;

  typedef logic [7:0] payload_t[$];

  logic clk;
  logic rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  ccd_in_if  in_chan ();
  ccd_out_if out_chan ();

  crc_chunk_deframer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_chan     (in_chan),
    .out_chan    (out_chan)
  );

  // Predictor copy of the registers and the parser
  logic [15:0] max_len       = MaxPayloadReset;
  logic        check_on      = 1'b1;
  logic        hdr_msb_first = 1'b1;
  ccd_phase_e  parse_phase;
  logic [2:0]  hdr_cnt;
  logic [31:0] crc_field;
  logic [15:0] len_left;
  logic [31:0] crc_acc;

  ccd_result_t deframed_results[$];

  bit          no_idle = 1'b0;
  int unsigned bytes_sent, results_checked, chunks_closed, crc_mismatches;
  int unsigned errors, cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("** crc_chunk_deframer: FAILED **");
      $finish;
    end
  end

  function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
    c[7:0] = c[7:0] ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPolyRefl) : (c >> 1);
    end
    return c;
  endfunction

  function automatic ccd_status_e crc_verdict();
    return (check_on && crc_acc != crc_field) ? StBadCrc : StOk;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic payload_t random_payload(input int unsigned n);
    payload_t p;
    repeat (n) p = {p, 8'($urandom_range(0, 255))};
    return p;
  endfunction

  task automatic clear_chunk_state();
    parse_phase = PhHeader;
    hdr_cnt     = '0;
    crc_field   = '0;
    len_left    = '0;
    crc_acc     = CrcInitRefl;
  endtask

  task automatic close_chunk(inout ccd_result_t r, input ccd_status_e st);
    r.chunk_end    = 1'b1;
    r.chunk_status = st;
    chunks_closed++;
    if (st == StBadCrc) crc_mismatches++;
    deframed_results = {deframed_results, r};
  endtask

  // Advance the parser by one accepted byte and queue any result it causes
  task automatic deframe_byte(input logic [7:0] b);
    ccd_result_t r;
    r = '{out_byte: 8'h00, has_byte: 1'b0, chunk_end: 1'b0, chunk_status: StOk};
    case (parse_phase)
      PhHeader: begin
        if (hdr_cnt < HdrCrcEnd) begin
          if (hdr_msb_first) crc_field = {crc_field[23:0], b};
          else crc_field = crc_field | (32'(b) << (8 * hdr_cnt));
          hdr_cnt++;
        end else if (hdr_cnt == HdrLenHi) begin
          len_left = hdr_msb_first ? {b, 8'h00} : {8'h00, b};
          hdr_cnt  = 3'd5;
        end else begin
          if (hdr_msb_first) len_left[7:0] = b;
          else len_left[15:8] = b;
          hdr_cnt = '0;
          if (len_left > max_len) begin
            parse_phase = PhDrop;
            close_chunk(r, StTooLong);
          end else if (len_left == 16'd0) begin
            close_chunk(r, crc_verdict());
            clear_chunk_state();
          end else begin
            parse_phase = PhPayload;
          end
        end
      end
      PhPayload: begin
        crc_acc    = crc_update(crc_acc, b);
        len_left   = len_left - 16'd1;
        r.out_byte = b;
        r.has_byte = 1'b1;
        if (len_left == 16'd0) begin
          close_chunk(r, crc_verdict());
          clear_chunk_state();
        end else begin
          deframed_results = {deframed_results, r};
        end
      end
      default: ;  // drop everything until reset
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    @(negedge clk);
    in_chan.valid   <= 1'b1;
    in_chan.in_byte <= b;
    do @(posedge clk); while (!in_chan.ready);
    deframe_byte(b);
    bytes_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_header(input logic [31:0] crc, input logic [15:0] len);
    if (hdr_msb_first) begin
      for (int i = 3; i >= 0; i--) send_byte(crc[8*i +: 8]);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else begin
      for (int i = 0; i < 4; i++) send_byte(crc[8*i +: 8]);
      send_byte(len[7:0]);
      send_byte(len[15:8]);
    end
  endtask

  task automatic send_chunk(input payload_t pl, input bit corrupt);
    logic [31:0] crc;
    crc = CrcInitRefl;
    foreach (pl[i]) crc = crc_update(crc, pl[i]);
    if (corrupt) crc = crc ^ (32'd1 << $urandom_range(0, 31));
    send_header(crc, 16'(pl.size()));
    foreach (pl[i]) send_byte(pl[i]);
  endtask

  // Hold valid low and let every outstanding request through the pipeline
  task automatic wait_idle();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (deframed_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CfgMaxPayload: max_len       = data;
      CfgCrcEnable:  check_on      = data[0];
      CfgBigEndian:  hdr_msb_first = data[0];
      default: ;
    endcase
  endtask

  task automatic write_cfg(input logic [15:0] max_p, input bit crc_en, input bit big_end);
    write_reg(CfgMaxPayload, max_p);
    write_reg(CfgCrcEnable, CfgDataW'(crc_en));
    write_reg(CfgBigEndian, CfgDataW'(big_end));
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    ccd_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (deframed_results.size() == 0) begin
        $error("unexpected result: out_byte %0h has_byte %0b chunk_end %0b status %0d",
               out_chan.out_byte, out_chan.has_byte, out_chan.chunk_end,
               out_chan.chunk_status);
        errors++;
      end else begin
        want = deframed_results.pop_front();
        check_field("out_byte", want.out_byte, out_chan.out_byte);
        check_field("has_byte", want.has_byte, out_chan.has_byte);
        check_field("chunk_end", want.chunk_end, out_chan.chunk_end);
        check_field("chunk_status", want.chunk_status, out_chan.chunk_status);
        results_checked++;
      end
    end
  end

  // Result side: stall at random, hold ready high while a burst runs
  initial begin : drive_out_ready
    int unsigned stall_left;
    stall_left     = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0 && !no_idle) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  task automatic test_basic_chunks();
    payload_t none, ones, zeros;
    ones  = {8'hFF};
    zeros = {8'h00};
    send_chunk(none, 1'b0);
    send_chunk(ones, 1'b1);
    send_chunk(zeros, 1'b0);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    payload_t none;
    // zero limit still admits an empty chunk; a bad CRC passes with checking off
    write_cfg(16'h0000, 1'b0, 1'b0);
    send_chunk(none, 1'b1);
    wait_idle();
  endtask

  task automatic test_mid_chunk_registers();
    logic [31:0] crc;
    crc = crc_update(CrcInitRefl, 8'hA5);
    write_cfg(16'h0000, 1'b1, 1'b0);
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
    wait_idle();
    // switch byte order halfway through the CRC field
    write_reg(CfgBigEndian, CfgDataW'(1));
    send_byte(crc[23:16]);
    send_byte(crc[31:24]);
    send_byte(8'h00);
    wait_idle();
    // the limit only counts at the last header byte
    write_reg(CfgMaxPayload, 16'd1);
    send_byte(8'h01);
    send_byte(8'hA5);
    wait_idle();
  endtask

  task automatic run_traffic_phase(input logic [15:0] max_p, input bit crc_en,
                                   input bit big_end, input int unsigned budget,
                                   input bit with_long);
    int unsigned start, cap, len, r;
    write_cfg(max_p, crc_en, big_end);
    start = bytes_sent;
    cap   = (max_p < 24) ? max_p : 24;
    if (with_long) send_chunk(random_payload($urandom_range(256, 300)), 1'b0);
    while (bytes_sent - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 10 || cap == 0) len = 0;
      else if (r < 20) len = cap;
      else len = $urandom_range(1, cap);
      no_idle = ($urandom_range(0, 4) == 0);
      send_chunk(random_payload(len), $urandom_range(0, 4) == 0);
    end
    no_idle = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(16'hFFFF, 1'b1, 1'b1, 130, 1'b0);
    run_traffic_phase(16'd3, 1'b1, 1'b0, 130, 1'b0);
    run_traffic_phase(16'($urandom_range(16, 400)), 1'b0, 1'($urandom_range(0, 1)), 130, 1'b0);
    run_traffic_phase(16'hFFFE, 1'b1, 1'b0, 130, 1'b1);
  endtask

  task automatic test_too_long_lockout();
    logic [15:0] limit_len;
    limit_len = 16'($urandom_range(0, 1000));
    write_cfg(limit_len, 1'b1, 1'($urandom_range(0, 1)));
    send_header($urandom(), 16'($urandom_range(limit_len + 1, 65535)));
    // everything after the oversize header is dropped
    repeat (12) send_byte(8'($urandom_range(0, 255)));
    wait_idle();
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_chan.valid   = 1'b0;
    in_chan.in_byte = '0;
    clear_chunk_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_chunks();
    test_register_extremes();
    test_mid_chunk_registers();
    test_random_traffic();
    test_too_long_lockout();

    $display("Sent %0d bytes; checked %0d results over %0d chunks, %0d with a CRC mismatch,",
             bytes_sent, results_checked, chunks_closed, crc_mismatches);
    $display("across both byte orders, CRC checking on and off, and a final too-long lockout.");
    if (errors == 0) begin
      $display("** crc_chunk_deframer: PASSED **");
    end else begin
      $display("** crc_chunk_deframer: FAILED **");
    end
    $finish;
  end

endmodule
